>>> rtl/cholrf_pkg.sv
package cholrf_pkg;

  localparam int unsigned MAX_DIM_DEF   = 8;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned IDX_W         = 3;
  localparam int unsigned DIM_W         = 4;
  localparam int unsigned VAL_W         = 32;
  localparam int unsigned ACC_W         = 64;

  typedef enum logic {
    OP_DIV,
    OP_SQRT
  } unit_op_e;

  typedef struct packed {
    logic     start;
    unit_op_e op;
  } unit_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ENTRY,
    S_DOT_RD,
    S_DOT_MUL,
    S_DOT_ACC,
    S_RES_RD,
    S_RES,
    S_CHK,
    S_UNIT,
    S_EMIT_RD,
    S_EMIT_LD,
    S_EMIT_WAIT
  } state_e;

  // first store entry of a packed lower-triangle row
  function automatic logic [5:0] tri_base(input logic [IDX_W-1:0] row);
    logic [6:0] prod;
    prod = 7'({3'b000, row} * ({3'b000, row} + 4'd1));
    return prod[6:1];
  endfunction

endpackage

>>> rtl/cholrf_unit.sv
module cholrf_unit
  import cholrf_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  unit_ctl_t               ctl_i,
  input  logic [ACC_W-1:0]        num_i,
  input  logic [VAL_W-1:0]        den_i,
  output logic                    done_o,
  output logic [VAL_W-1:0]        res_o
);

  logic              busy_q, done_q;
  unit_op_e          op_q;
  logic [5:0]        cnt_q;
  logic [ACC_W-1:0]  x_q;
  logic [34:0]       rem_q;
  logic [62:0]       q_q;
  logic [VAL_W-1:0]  den_q;
  logic [5:0]        last_cnt;
  logic [31:0]       dtrial;
  logic [34:0]       strial, sroot;

  assign last_cnt = (op_q == OP_DIV) ? 6'd62 : 6'd31;
  assign dtrial   = {rem_q[30:0], x_q[63]};
  assign strial   = {rem_q[32:0], x_q[63:62]};
  assign sroot    = {1'b0, q_q[31:0], 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == last_cnt) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      op_q  <= ctl_i.op;
      den_q <= den_i;
      rem_q <= '0;
      q_q   <= '0;
      x_q   <= (ctl_i.op == OP_DIV) ? {num_i[62:0], 1'b0} : num_i;
    end else if (busy_q) begin
      if (op_q == OP_DIV) begin
        x_q <= {x_q[62:0], 1'b0};
        if (dtrial >= den_q) begin
          rem_q <= {3'b000, dtrial - den_q};
          q_q   <= {q_q[61:0], 1'b1};
        end else begin
          rem_q <= {3'b000, dtrial};
          q_q   <= {q_q[61:0], 1'b0};
        end
      end else begin
        x_q <= {x_q[61:0], 2'b00};
        if (strial >= sroot) begin
          rem_q <= strial - sroot;
          q_q   <= {q_q[61:0], 1'b1};
        end else begin
          rem_q <= strial;
          q_q   <= {q_q[61:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    if (op_q == OP_DIV) begin
      res_o = (q_q > 63'h8000_0000) ? 32'h8000_0000 : q_q[31:0];
    end else begin
      res_o = q_q[31] ? 32'h7FFF_FFFF : q_q[31:0];
    end
  end

  assign done_o = done_q;

endmodule

>>> rtl/cholesky_row_factorizer.sv
// Cholesky row factorizer, signed fixed point (Q16.16 by default).
// Input stream: one lower-triangle element per word on s_axis_tdata, row by
// row, diagonal last; row r takes r+1 words. Input is taken only while the
// block is idle. Output stream: when a row is complete, r+1 words of L, in
// column order; tlast marks the diagonal entry, tuser carries the end of
// matrix mark and the sticky pivot error flag.
// Per row r, for each entry j: a dot product over j terms (one shared
// multiplier, one factor store read pair per term), residual handling and
// the shared divider (square root on the diagonal); then each word is
// emitted through read, load and wait states, plus receiver stall.
// The cfg write sets the matrix order (clamped to 1..MAX_DIM) and restarts
// the matrix; write it only while idle. Reset sets order MAX_DIM, row 0,
// clears the error flag; the stores need no clearing. A stalled receiver
// holds the output word and the block waits on it.
module cholesky_row_factorizer
  import cholrf_pkg::*;
#(
  parameter int unsigned MAX_DIM   = MAX_DIM_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [DIM_W-1:0] cfg_wdata_i,    // matrix_dim
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [31:0]      s_axis_tdata,   // [31:0] a_value
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // [31:0] l_value, [34:32] row_index,
                                           // [37:35] col_index, [39:38] zero
  output logic             m_axis_tlast,   // row_last
  output logic [1:0]       m_axis_tuser    // [0] matrix_last, [1] pivot_error
);

  localparam int unsigned STORE_DEPTH = MAX_DIM * (MAX_DIM + 1) / 2;
  localparam int unsigned AW  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned RBW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam logic [ACC_W-1:0] LIM = 64'(1) << (62 - FRAC_BITS);

  state_e state_q, state_d;

  logic [DIM_W-1:0] dim_q, dim_act;
  logic [IDX_W-1:0] row_q, col_q, j_q, k_q, e_q;
  logic [IDX_W-1:0] r_eff, c_eff;
  logic             err_q;
  logic             last_row;

  logic signed [VAL_W-1:0] fs_mem [STORE_DEPTH];
  logic signed [VAL_W-1:0] rb_mem [MAX_DIM];
  logic signed [VAL_W-1:0] rd_a_q, rd_b_q, rb_q;
  logic signed [ACC_W-1:0] prod_q, acc_q, res_q;

  logic             fs_rd, fs_we, rb_rd, in_acc;
  logic [AW-1:0]    addr_a, addr_b, addr_w;
  logic [VAL_W-1:0] wdata;
  logic [5:0]       base_r;

  unit_ctl_t        uctl;
  logic [ACC_W-1:0] unum;
  logic             udone;
  logic [VAL_W-1:0] ures;

  logic             neg;
  logic [ACC_W-1:0] mag, magc;
  logic             diag, bad;

  assign dim_act = (dim_q == '0) ? DIM_W'(1)
                 : ((dim_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : dim_q);
  assign r_eff   = ({1'b0, row_q} >= dim_act) ? '0 : row_q;
  assign c_eff   = (({1'b0, row_q} >= dim_act) || (col_q > r_eff)) ? '0 : col_q;
  assign last_row = ({1'b0, row_q} + 4'd1) == dim_act;
  assign base_r  = tri_base(row_q);
  assign diag    = (j_q == row_q);
  assign in_acc  = s_axis_tvalid && s_axis_tready;

  assign neg  = res_q[ACC_W-1];
  assign mag  = neg ? ACC_W'(-res_q) : ACC_W'(res_q);
  assign magc = (mag > LIM) ? LIM : mag;
  assign bad  = diag ? (res_q <= 0) : (rd_b_q <= 0);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:      if (in_acc && (c_eff >= r_eff)) state_d = S_ENTRY;
      S_ENTRY:     state_d = (j_q == '0) ? S_RES_RD : S_DOT_RD;
      S_DOT_RD:    state_d = S_DOT_MUL;
      S_DOT_MUL:   state_d = S_DOT_ACC;
      S_DOT_ACC:   state_d = (k_q + 3'd1 == j_q) ? S_RES_RD : S_DOT_RD;
      S_RES_RD:    state_d = S_RES;
      S_RES:       state_d = S_CHK;
      S_CHK: begin
        if (bad) state_d = diag ? S_EMIT_RD : S_ENTRY;
        else     state_d = S_UNIT;
      end
      S_UNIT:      if (udone) state_d = diag ? S_EMIT_RD : S_ENTRY;
      S_EMIT_RD:   state_d = S_EMIT_LD;
      S_EMIT_LD:   state_d = S_EMIT_WAIT;
      S_EMIT_WAIT: if (m_axis_tready) state_d = (e_q == row_q) ? S_IDLE : S_EMIT_RD;
      default:     state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready = 1'b0;
    fs_rd         = 1'b0;
    rb_rd         = 1'b0;
    fs_we         = 1'b0;
    addr_a        = AW'(base_r + 6'(k_q));
    addr_b        = AW'(tri_base(j_q) + 6'(k_q));
    addr_w        = AW'(base_r + 6'(j_q));
    wdata         = '0;
    uctl.start    = 1'b0;
    uctl.op       = diag ? OP_SQRT : OP_DIV;
    unum          = diag ? ACC_W'(res_q) << FRAC_BITS : ACC_W'(magc << FRAC_BITS);
    unique case (state_q)
      S_IDLE:    s_axis_tready = 1'b1;
      S_DOT_RD:  fs_rd = 1'b1;
      S_RES_RD: begin
        fs_rd  = 1'b1;
        rb_rd  = 1'b1;
        addr_b = AW'(tri_base(j_q) + 6'(j_q));
      end
      S_CHK: begin
        if (bad) fs_we = 1'b1;
        else     uctl.start = 1'b1;
      end
      S_UNIT: begin
        fs_we = udone;
        if (diag) wdata = ures;
        else if (neg) wdata = VAL_W'(-{1'b0, ures});
        else wdata = ures[31] ? 32'h7FFF_FFFF : ures;
      end
      S_EMIT_RD: begin
        fs_rd  = 1'b1;
        addr_a = AW'(base_r + 6'(e_q));
      end
      default: ;
    endcase
  end

  // factor store and row buffer
  always_ff @(posedge clk_i) begin
    if (fs_we) fs_mem[addr_w] <= wdata;
    if (fs_rd) begin
      rd_a_q <= fs_mem[addr_a];
      rd_b_q <= fs_mem[addr_b];
    end
    if (in_acc) rb_mem[c_eff[RBW-1:0]] <= s_axis_tdata;
    if (rb_rd)  rb_q <= rb_mem[j_q[RBW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_ENTRY:   acc_q <= '0;
      S_DOT_MUL: prod_q <= ACC_W'(rd_a_q) * ACC_W'(rd_b_q);
      S_DOT_ACC: acc_q <= acc_q + (prod_q >>> FRAC_BITS);
      S_RES:     res_q <= ACC_W'(rb_q) - acc_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      dim_q         <= DIM_W'(MAX_DIM);
      row_q         <= '0;
      col_q         <= '0;
      j_q           <= '0;
      k_q           <= '0;
      e_q           <= '0;
      err_q         <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        dim_q <= cfg_wdata_i;
        row_q <= '0;
        col_q <= '0;
        err_q <= 1'b0;
      end
      if (in_acc) begin
        row_q <= r_eff;
        j_q   <= '0;
        col_q <= (c_eff < r_eff) ? c_eff + 3'd1 : '0;
      end
      if (state_q == S_ENTRY)   k_q <= '0;
      if (state_q == S_DOT_ACC) k_q <= k_q + 3'd1;
      if ((state_q == S_CHK) && bad) err_q <= 1'b1;
      if (fs_we) begin
        if (diag) e_q <= '0;
        else      j_q <= j_q + 3'd1;
      end
      if (state_q == S_EMIT_LD) m_axis_tvalid <= 1'b1;
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
        e_q <= e_q + 3'd1;
        if (e_q == row_q) begin
          // row done: advance, or wrap at the end of the matrix
          if (last_row) begin
            row_q <= '0;
            err_q <= 1'b0;
          end else begin
            row_q <= row_q + 3'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_EMIT_LD) begin
      m_axis_tdata <= {2'b00, e_q, row_q, rd_a_q};
      m_axis_tlast <= (e_q == row_q);
      m_axis_tuser <= {err_q, (e_q == row_q) && last_row};
    end
  end

  cholrf_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (uctl),
    .num_i  (unum),
    .den_i  (rd_b_q),
    .done_o (udone),
    .res_o  (ures)
  );

`ifndef SYNTHESIS
  a_out_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> state_q == S_EMIT_WAIT)
    else $error("output word valid outside emit");
  a_done_in_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    udone |-> state_q == S_UNIT)
    else $error("unit result with no waiting entry");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input taken while output pending");
  a_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fs_we |-> 32'(addr_w) < STORE_DEPTH)
    else $error("factor store write beyond depth");
`endif

endmodule
